// ----- src/pcsd_pkg.sv -----
// Shared types and constants for the pin-change subscription dispatcher.
// Used by pcsd_slot_scan and pin_change_subscription_dispatch_core.
// No dependencies.
package pcsd_pkg;

   // Default table size
   localparam int SLOTS_DEFAULT = 16;

   // Field widths
   localparam int SLOT_W = 4;
   localparam int PIN_W  = 4;
   localparam int LVL_W  = 8;
   localparam int CHG_W  = 5;
   localparam int BIT_W  = 3;

   // Request function codes
   localparam logic [1:0] FUNC_SUBSCRIBE   = 2'd0;
   localparam logic [1:0] FUNC_UNSUBSCRIBE = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE      = 2'd2;
   localparam logic [1:0] FUNC_INIT        = 2'd3;

   // Port select codes
   localparam logic [1:0] PORT_B = 2'd0;
   localparam logic [1:0] PORT_A = 2'd1;
   localparam logic [1:0] PORT_D = 2'd2;

   // First logical pin of each port's mapped bits
   localparam logic [PIN_W-1:0] PIN_BASE_B = 4'd0;
   localparam logic [PIN_W-1:0] PIN_BASE_A = 4'd10;
   localparam logic [PIN_W-1:0] PIN_BASE_D = 4'd5;

   // Result kind codes
   localparam logic [1:0] KIND_SUBSCRIBE   = 2'd0;
   localparam logic [1:0] KIND_UNSUBSCRIBE = 2'd1;
   localparam logic [1:0] KIND_DISPATCH    = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB_WAIT,
      ST_UNSUB_WAIT,
      ST_PICK,
      ST_PIN_WAIT,
      ST_FLUSH
   } state_type;

   // What the slot scanner looks for
   typedef enum logic {
      SCAN_FREE,
      SCAN_MATCH
   } scan_mode_type;

   // Scan launch
   typedef struct packed {
      logic               start;
      scan_mode_type      mode;
      logic [PIN_W-1:0]   pin;
   } scan_req_type;

   // Scan outcome, valid for one cycle on done
   typedef struct packed {
      logic               done;
      logic               found;
      logic [SLOT_W-1:0]  slot;
   } scan_rsp_type;

   // Table update
   typedef struct packed {
      logic               claim;
      logic               release_slot;
      logic [SLOT_W-1:0]  slot;
      logic [PIN_W-1:0]   pin;
   } tbl_wr_type;

endpackage

// ----- src/pcsd_slot_scan.sv -----
// Subscription slot table with a shared one-slot-per-cycle compare unit.
// Finds the lowest free slot or the lowest used slot holding a pin.
// Depends on pcsd_pkg.
module pcsd_slot_scan #(
   parameter int SLOTS = pcsd_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pcsd_pkg::scan_req_type scan_req,
   input  pcsd_pkg::tbl_wr_type   tbl_wr,
   output pcsd_pkg::scan_rsp_type scan_rsp
);

   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

   logic [SLOTS-1:0]               used_ff, used_in;
   logic [pcsd_pkg::PIN_W-1:0]     pin_ff [SLOTS];
   logic [pcsd_pkg::PIN_W-1:0]     pin_in [SLOTS];
   logic                           busy_ff, busy_in;
   logic [IdxW-1:0]                idx_ff, idx_in;
   pcsd_pkg::scan_mode_type        mode_ff, mode_in;
   logic [pcsd_pkg::PIN_W-1:0]     target_ff, target_in;
   pcsd_pkg::scan_rsp_type         rsp_ff, rsp_in;
   logic                           entry_hit;

   // Compare unit: one entry per cycle
   always_comb begin
      case (mode_ff)
         pcsd_pkg::SCAN_FREE:  entry_hit = !used_ff[idx_ff];
         pcsd_pkg::SCAN_MATCH: entry_hit = used_ff[idx_ff] && (pin_ff[idx_ff] == target_ff);
         default:              entry_hit = 1'b0;
      endcase
   end

   // Scan walk
   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      mode_in   = mode_ff;
      target_in = target_ff;
      rsp_in    = '0;
      if (scan_req.start) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         mode_in   = scan_req.mode;
         target_in = scan_req.pin;
      end else if (busy_ff) begin
         if (entry_hit) begin
            busy_in      = 1'b0;
            rsp_in.done  = 1'b1;
            rsp_in.found = 1'b1;
            rsp_in.slot  = pcsd_pkg::SLOT_W'(idx_ff);
         end else if (idx_ff == LastIdx) begin
            busy_in     = 1'b0;
            rsp_in.done = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   // Table updates
   always_comb begin
      used_in = used_ff;
      pin_in  = pin_ff;
      if (tbl_wr.claim) begin
         used_in[tbl_wr.slot[IdxW-1:0]] = 1'b1;
         pin_in[tbl_wr.slot[IdxW-1:0]]  = tbl_wr.pin;
      end
      if (tbl_wr.release_slot) begin
         used_in[tbl_wr.slot[IdxW-1:0]] = 1'b0;
         pin_in[tbl_wr.slot[IdxW-1:0]]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            pin_ff[i] <= '0;
         end
         busy_ff <= 1'b0;
         rsp_ff  <= '0;
      end else begin
         used_ff <= used_in;
         pin_ff  <= pin_in;
         busy_ff <= busy_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mode_ff   <= mode_in;
      target_ff <= target_in;
   end

   assign scan_rsp = rsp_ff;

endmodule

// ----- src/pin_change_subscription_dispatch_core.sv -----
// Pin-change subscription dispatcher, top level.
// Subscribe/unsubscribe: a single slot scan runs from accept to the reply beat; the scan
// checks one slot per cycle. Port sample: one slot scan per changed mapped bit, lowest
// bit first; init capture only stores the port level.
// One item at a time: busy stays high until the last result beat is registered. Results
// cannot be stalled. Synchronous reset clears the slot table, stored port levels and control.
module pin_change_subscription_dispatch_core #(
   parameter int SLOTS = pcsd_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_func,
   input  logic [pcsd_pkg::PIN_W-1:0]   req_pin_id,
   input  logic [1:0]                   req_port_sel,
   input  logic [pcsd_pkg::LVL_W-1:0]   req_port_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_kind,
   output logic                         rsp_ok,
   output logic [pcsd_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [pcsd_pkg::PIN_W-1:0]   rsp_pin_out,
   output logic                         rsp_last
);

   pcsd_pkg::state_type              state_ff, state_in;
   logic [pcsd_pkg::LVL_W-1:0]       level_ff [3];
   logic [pcsd_pkg::LVL_W-1:0]       level_in [3];
   logic [pcsd_pkg::CHG_W-1:0]       chg_ff, chg_in;
   logic [pcsd_pkg::PIN_W-1:0]       base_ff, base_in;
   logic [pcsd_pkg::PIN_W-1:0]       cur_pin_ff, cur_pin_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [pcsd_pkg::SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [pcsd_pkg::PIN_W-1:0]       pend_pin_ff, pend_pin_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_kind_ff, rsp_kind_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [pcsd_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [pcsd_pkg::PIN_W-1:0]       rsp_pin_ff, rsp_pin_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             accept;
   logic                             sel_ok;
   logic [pcsd_pkg::LVL_W-1:0]       diff;
   logic [pcsd_pkg::BIT_W-1:0]       low_idx;
   logic [pcsd_pkg::PIN_W-1:0]       pick_pin;
   pcsd_pkg::scan_req_type           scan_req;
   pcsd_pkg::scan_rsp_type           scan_rsp;
   pcsd_pkg::tbl_wr_type             tbl_wr;

   // Lowest set bit of the changed-pin vector
   function automatic logic [pcsd_pkg::BIT_W-1:0] low_bit(
      input logic [pcsd_pkg::CHG_W-1:0] v
   );
      logic [pcsd_pkg::BIT_W-1:0] r;
      r = '0;
      for (int i = pcsd_pkg::CHG_W - 1; i >= 0; i--) begin
         if (v[i]) r = pcsd_pkg::BIT_W'(i);
      end
      return r;
   endfunction

   pcsd_slot_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .tbl_wr   (tbl_wr),
      .scan_rsp (scan_rsp)
   );

   assign busy     = (state_ff != pcsd_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign sel_ok   = req_port_sel inside {pcsd_pkg::PORT_B, pcsd_pkg::PORT_A, pcsd_pkg::PORT_D};
   assign diff     = sel_ok ? (level_ff[req_port_sel] ^ req_port_value) : '0;
   assign low_idx  = low_bit(chg_ff);
   assign pick_pin = base_ff + {1'b0, low_idx};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcsd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  pcsd_pkg::FUNC_SUBSCRIBE:   state_in = pcsd_pkg::ST_SUB_WAIT;
                  pcsd_pkg::FUNC_UNSUBSCRIBE: state_in = pcsd_pkg::ST_UNSUB_WAIT;
                  pcsd_pkg::FUNC_SAMPLE:      state_in = sel_ok ? pcsd_pkg::ST_PICK
                                                                : pcsd_pkg::ST_IDLE;
                  default:                    state_in = pcsd_pkg::ST_IDLE;
               endcase
            end
         end
         pcsd_pkg::ST_SUB_WAIT,
         pcsd_pkg::ST_UNSUB_WAIT: begin
            if (scan_rsp.done) state_in = pcsd_pkg::ST_IDLE;
         end
         pcsd_pkg::ST_PICK: begin
            state_in = (chg_ff != '0) ? pcsd_pkg::ST_PIN_WAIT : pcsd_pkg::ST_FLUSH;
         end
         pcsd_pkg::ST_PIN_WAIT: begin
            if (scan_rsp.done) state_in = pcsd_pkg::ST_PICK;
         end
         pcsd_pkg::ST_FLUSH: state_in = pcsd_pkg::ST_IDLE;
         default:            state_in = pcsd_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      level_in      = level_ff;
      chg_in        = chg_ff;
      base_in       = base_ff;
      cur_pin_in    = cur_pin_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_pin_in   = pend_pin_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pin_in    = rsp_pin_ff;
      rsp_last_in   = rsp_last_ff;
      scan_req      = '0;
      tbl_wr        = '0;
      case (state_ff)
         pcsd_pkg::ST_IDLE: begin
            if (accept) begin
               cur_pin_in = req_pin_id;
               case (req_func)
                  pcsd_pkg::FUNC_SUBSCRIBE: begin
                     scan_req.start = 1'b1;
                     scan_req.mode  = pcsd_pkg::SCAN_FREE;
                     scan_req.pin   = req_pin_id;
                  end
                  pcsd_pkg::FUNC_UNSUBSCRIBE: begin
                     scan_req.start = 1'b1;
                     scan_req.mode  = pcsd_pkg::SCAN_MATCH;
                     scan_req.pin   = req_pin_id;
                  end
                  pcsd_pkg::FUNC_SAMPLE: begin
                     if (sel_ok) begin
                        level_in[req_port_sel] = req_port_value;
                        pend_valid_in = 1'b0;
                        case (req_port_sel)
                           pcsd_pkg::PORT_B: begin
                              chg_in  = diff[4:0];
                              base_in = pcsd_pkg::PIN_BASE_B;
                           end
                           pcsd_pkg::PORT_A: begin
                              chg_in  = {3'b000, diff[1:0]};
                              base_in = pcsd_pkg::PIN_BASE_A;
                           end
                           pcsd_pkg::PORT_D: begin
                              chg_in  = diff[6:2];
                              base_in = pcsd_pkg::PIN_BASE_D;
                           end
                           default: begin
                              chg_in  = '0;
                              base_in = pcsd_pkg::PIN_BASE_B;
                           end
                        endcase
                     end
                  end
                  default: begin
                     // init capture: store the level only
                     if (sel_ok) level_in[req_port_sel] = req_port_value;
                  end
               endcase
            end
         end
         pcsd_pkg::ST_SUB_WAIT: begin
            if (scan_rsp.done) begin
               tbl_wr.claim  = scan_rsp.found;
               tbl_wr.slot   = scan_rsp.slot;
               tbl_wr.pin    = cur_pin_ff;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pcsd_pkg::KIND_SUBSCRIBE;
               rsp_ok_in     = scan_rsp.found;
               rsp_slot_in   = scan_rsp.slot;
               rsp_pin_in    = cur_pin_ff;
               rsp_last_in   = 1'b1;
            end
         end
         pcsd_pkg::ST_UNSUB_WAIT: begin
            if (scan_rsp.done) begin
               tbl_wr.release_slot = scan_rsp.found;
               tbl_wr.slot         = scan_rsp.slot;
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pcsd_pkg::KIND_UNSUBSCRIBE;
               rsp_ok_in           = scan_rsp.found;
               rsp_slot_in         = scan_rsp.slot;
               rsp_pin_in          = cur_pin_ff;
               rsp_last_in         = 1'b1;
            end
         end
         pcsd_pkg::ST_PICK: begin
            // launch a scan for the next changed pin, lowest bit first
            if (chg_ff != '0) begin
               scan_req.start  = 1'b1;
               scan_req.mode   = pcsd_pkg::SCAN_MATCH;
               scan_req.pin    = pick_pin;
               cur_pin_in      = pick_pin;
               chg_in[low_idx] = 1'b0;
            end
         end
         pcsd_pkg::ST_PIN_WAIT: begin
            // hold one dispatch back so the final beat can carry last
            if (scan_rsp.done && scan_rsp.found) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pcsd_pkg::KIND_DISPATCH;
                  rsp_ok_in    = 1'b1;
                  rsp_slot_in  = pend_slot_ff;
                  rsp_pin_in   = pend_pin_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = scan_rsp.slot;
               pend_pin_in   = cur_pin_ff;
            end
         end
         pcsd_pkg::ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pcsd_pkg::KIND_DISPATCH;
               rsp_ok_in    = 1'b1;
               rsp_slot_in  = pend_slot_ff;
               rsp_pin_in   = pend_pin_ff;
               rsp_last_in  = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcsd_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         level_ff      <= level_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chg_ff       <= chg_in;
      base_ff      <= base_in;
      cur_pin_ff   <= cur_pin_in;
      pend_slot_ff <= pend_slot_in;
      pend_pin_ff  <= pend_pin_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_pin_ff   <= rsp_pin_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_pin_out = rsp_pin_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
